FILE: rtl/page_framebuffer_draw_engine_defines.svh
// Assertion macros for the frame store draw engine.
`ifndef PAGE_FRAMEBUFFER_DRAW_ENGINE_DEFINES_SVH
`define PAGE_FRAMEBUFFER_DRAW_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define PFDE_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error(msg);
`define PFDE_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PFDE_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg)
`define PFDE_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg)
`endif
`endif

FILE: rtl/pfde_pkg.sv
`timescale 1ns / 1ps
package pfde_pkg;

	localparam int SCREEN_WIDTH  = 132;
	localparam int SCREEN_HEIGHT = 64;
	localparam int PAGE_ROWS     = 8;
	localparam int PAGE_COUNT    = (SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
	localparam int STORE_BYTES   = SCREEN_WIDTH * PAGE_COUNT;
	localparam int ADDR_W        = $clog2(STORE_BYTES);

	// coordinate width: covers corner + span and centre +/- radius
	localparam int CW    = 14;
	// line numerator, its magnitude, and the major span
	localparam int NUM_W = 26;
	localparam int MAG_W = 25;
	localparam int DVS_W = 12;

	typedef enum logic [2:0] {
		REQ_PIXEL   = 3'd0,
		REQ_OUTLINE = 3'd1,
		REQ_FILL    = 3'd2,
		REQ_LINE    = 3'd3,
		REQ_DISC    = 3'd4,
		REQ_READ    = 3'd5
	} req_t;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_CLEAR,
		OP_LOAD,
		OP_BOX,
		OP_LINE_A,
		OP_LINE_B,
		OP_LINE_C,
		OP_LINE_D,
		OP_CALC,
		OP_READ,
		OP_WRITE,
		OP_RDBYTE,
		OP_RESULT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   div_start;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic box_empty;
		logic last_px;
		logic is_line;
		logic div_done;
		logic out_free;
	} dp_stat_t;

endpackage

FILE: rtl/pfde_div.sv
`timescale 1ns / 1ps
module pfde_div import pfde_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [MAG_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [MAG_W-1:0] quotient
);

	localparam int CNT_W = $clog2(MAG_W + 1);

	logic [MAG_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DVS_W:0]   shifted;
	logic [DVS_W+1:0] trial;
	logic             fits;

	// restoring, one quotient bit a cycle
	assign shifted = {rem_q, quo_q[MAG_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, dvs_q};
	assign fits    = !trial[DVS_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(MAG_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
			quo_q <= {quo_q[MAG_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: rtl/pfde_ctrl.sv
`timescale 1ns / 1ps
module pfde_ctrl import pfde_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [2:0] req_type,
	input  dp_stat_t   stat,
	output logic       in_stall,
	output dp_cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_BOX,
		S_LINE_A,
		S_LINE_B,
		S_LINE_C,
		S_LINE_D,
		S_CHECK,
		S_CALC,
		S_DIV_WAIT,
		S_READ,
		S_WRITE,
		S_RDBYTE,
		S_DONE
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (stat.clr_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						unique case (req_type) inside
							REQ_PIXEL, REQ_OUTLINE, REQ_FILL, REQ_DISC: state_q <= S_BOX;
							REQ_LINE: state_q <= S_LINE_A;
							REQ_READ: state_q <= S_RDBYTE;
							default:  state_q <= S_DONE;
						endcase
					end
				end
				S_BOX:    state_q <= S_CHECK;
				S_LINE_A: state_q <= S_LINE_B;
				S_LINE_B: state_q <= S_LINE_C;
				S_LINE_C: state_q <= S_LINE_D;
				S_LINE_D: state_q <= S_CHECK;
				S_CHECK:  state_q <= stat.box_empty ? S_DONE : S_CALC;
				S_CALC:   state_q <= stat.is_line ? S_DIV_WAIT : S_READ;
				S_DIV_WAIT: begin
					if (stat.div_done) state_q <= S_READ;
				end
				S_READ:   state_q <= S_WRITE;
				S_WRITE:  state_q <= stat.last_px ? S_DONE : S_CALC;
				S_RDBYTE: state_q <= S_DONE;
				S_DONE: begin
					if (stat.out_free) state_q <= S_IDLE;
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.div_start = (state_q == S_CALC) && stat.is_line;
		unique case (state_q)
			S_CLEAR:  cmd.op = OP_CLEAR;
			S_IDLE:   cmd.op = in_valid ? OP_LOAD : OP_IDLE;
			S_BOX:    cmd.op = OP_BOX;
			S_LINE_A: cmd.op = OP_LINE_A;
			S_LINE_B: cmd.op = OP_LINE_B;
			S_LINE_C: cmd.op = OP_LINE_C;
			S_LINE_D: cmd.op = OP_LINE_D;
			S_CALC:   cmd.op = OP_CALC;
			S_READ:   cmd.op = OP_READ;
			S_WRITE:  cmd.op = OP_WRITE;
			S_RDBYTE: cmd.op = OP_RDBYTE;
			S_DONE:   cmd.op = stat.out_free ? OP_RESULT : OP_IDLE;
			default:  cmd.op = OP_IDLE;
		endcase
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

FILE: rtl/pfde_datapath.sv
`timescale 1ns / 1ps
module pfde_datapath import pfde_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_stat_t           stat,
	input  logic [2:0]         req_type,
	input  logic signed [11:0] x_a,
	input  logic signed [11:0] y_a,
	input  logic signed [11:0] x_b,
	input  logic signed [11:0] y_b,
	input  logic [10:0]        rect_width,
	input  logic [10:0]        rect_height,
	input  logic [10:0]        circle_radius,
	input  logic               ink,
	input  logic [10:0]        byte_index,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         read_data,
	output logic               is_read
);

	typedef enum logic [2:0] {
		K_PIXEL,
		K_OUTLINE,
		K_FILL,
		K_LINE,
		K_DISC,
		K_READ,
		K_NONE
	} kind_t;

	typedef logic signed [CW-1:0] crd_t;

	localparam crd_t XMAX = CW'(SCREEN_WIDTH - 1);
	localparam crd_t YMAX = CW'(SCREEN_HEIGHT - 1);

	function automatic crd_t sx12(input logic signed [11:0] v);
		return CW'(v);
	endfunction

	function automatic crd_t ux11(input logic [10:0] v);
		return $signed(CW'(v));
	endfunction

	function automatic crd_t clip_lo(input crd_t v);
		return (v < 0) ? crd_t'(0) : v;
	endfunction

	function automatic crd_t clip_hi(input crd_t v, input crd_t m);
		return (v > m) ? m : v;
	endfunction

	// latched command word
	kind_t              kind_q;
	logic signed [11:0] xa_q, ya_q, xb_q, yb_q;
	logic [10:0]        w_q, h_q, r_q;
	logic               ink_q;
	logic [10:0]        bi_q;

	// raster window and walk
	crd_t xl_q, xh_q, yl_q, yh_q;
	crd_t cur_x_q, cur_y_q;
	logic [2*CW-1:0] r2_q;
	logic [2*CW-1:0] sqdx_q, sqdy_q;

	// line set-up
	logic [2*CW-1:0]         sqx_q, sqy_q;
	logic                    xmaj_q;
	crd_t                    ms_q, me_q, ns_q, ne_q;
	crd_t                    d_q, dn_q;
	logic signed [2*CW-1:0]  p1_q, p2_q;
	logic signed [NUM_W-1:0] num_q;

	// pixel access
	logic [ADDR_W-1:0] addr_q;
	logic [7:0]        mask_q;
	logic              hit_q;
	logic [7:0]        rd_q;
	logic              rd_ok_q;
	logic [ADDR_W-1:0] clr_q;

	logic [7:0] mem [STORE_BYTES];

	logic       out_valid_q;
	logic [7:0] read_data_q;
	logic       is_read_q;

	crd_t xa_e, ya_e, xb_e, yb_e, x_far, y_far, r_e;
	crd_t bx_lo, bx_hi, by_lo, by_hi;
	crd_t dx_c, dy_c;
	crd_t m_s, m_e, n_s, n_e;
	crd_t d_c, dn_c, lim_hi, t_lo, t_hi;
	crd_t ddx, ddy;
	logic                    num_neg;
	logic signed [NUM_W-1:0] num_cur;
	logic                    cur_neg;
	logic signed [NUM_W-1:0] num_abs;
	logic                    div_done;
	logic [MAG_W-1:0]        quo;
	logic signed [NUM_W-1:0] quo_e, n_full;
	crd_t                    n_c;
	crd_t                    px_x, px_y;
	logic                    on_screen, shape_hit;
	logic [ADDR_W-1:0]       addr_c;
	logic [CW-5:0]           page;
	logic                    mem_we, mem_re;
	logic [ADDR_W-1:0]       waddr, raddr;
	logic [7:0]              wdata;
	logic                    last_px;

	assign xa_e  = sx12(xa_q);
	assign ya_e  = sx12(ya_q);
	assign xb_e  = sx12(xb_q);
	assign yb_e  = sx12(yb_q);
	assign r_e   = ux11(r_q);
	assign x_far = xa_e + ux11(w_q);
	assign y_far = ya_e + ux11(h_q);

	// unclipped window per shape
	always_comb begin
		case (kind_q)
			K_DISC: begin
				bx_lo = xa_e - r_e;
				bx_hi = xa_e + r_e;
				by_lo = ya_e - r_e;
				by_hi = ya_e + r_e;
			end
			K_OUTLINE, K_FILL: begin
				bx_lo = xa_e;
				bx_hi = x_far;
				by_lo = ya_e;
				by_hi = y_far;
			end
			default: begin
				bx_lo = xa_e;
				bx_hi = xa_e;
				by_lo = ya_e;
				by_hi = ya_e;
			end
		endcase
	end

	assign dx_c = xb_e - xa_e;
	assign dy_c = yb_e - ya_e;

	// major axis ordered low to high
	always_comb begin
		crd_t a_s, a_e, b_s, b_e;
		a_s = xmaj_q ? xa_e : ya_e;
		a_e = xmaj_q ? xb_e : yb_e;
		b_s = xmaj_q ? ya_e : xa_e;
		b_e = xmaj_q ? yb_e : xb_e;
		if (a_s > a_e) begin
			m_s = a_e;
			m_e = a_s;
			n_s = b_e;
			n_e = b_s;
		end else begin
			m_s = a_s;
			m_e = a_e;
			n_s = b_s;
			n_e = b_e;
		end
	end

	assign d_c    = me_q - ms_q;
	assign dn_c   = ne_q - ns_q;
	assign lim_hi = xmaj_q ? XMAX : YMAX;
	assign t_lo   = clip_lo(ms_q);
	assign t_hi   = clip_hi(me_q, lim_hi);

	assign ddx = cur_x_q - xa_e;
	assign ddy = cur_y_q - ya_e;

	// numerator for this step: seeded on the first step, stepped by dn after
	assign num_cur = (kind_q == K_LINE && cur_x_q == xl_q && cur_y_q == yl_q) ?
		NUM_W'(p1_q + p2_q) : num_q;
	assign cur_neg = num_cur[NUM_W-1];
	assign num_abs = cur_neg ? -num_cur : num_cur;
	assign num_neg = num_q[NUM_W-1];

	pfde_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (MAG_W'(num_abs)),
		.divisor  (d_q[DVS_W-1:0]),
		.done     (div_done),
		.quotient (quo)
	);

	// truncation toward zero: sign of the numerator on the magnitude quotient
	assign quo_e  = $signed(NUM_W'(quo));
	assign n_full = num_neg ? -quo_e : quo_e;
	assign n_c    = CW'(n_full);

	// a line walks its major coordinate in cur_x_q
	assign px_x = (kind_q == K_LINE) ? (xmaj_q ? cur_x_q : n_c) : cur_x_q;
	assign px_y = (kind_q == K_LINE) ? (xmaj_q ? n_c : cur_x_q) : cur_y_q;

	assign on_screen = (px_x >= 0) && (px_x <= XMAX) && (px_y >= 0) && (px_y <= YMAX);

	always_comb begin
		case (kind_q)
			K_PIXEL, K_FILL, K_LINE: shape_hit = 1'b1;
			K_OUTLINE: shape_hit = (cur_x_q == xa_e) || (cur_x_q == x_far) ||
				(cur_y_q == ya_e) || (cur_y_q == y_far);
			K_DISC:    shape_hit = (sqdx_q + sqdy_q) < r2_q;
			default:   shape_hit = 1'b0;
		endcase
	end

	assign page   = px_y[CW-2:3];
	assign addr_c = ADDR_W'(px_x[CW-2:0]) + ADDR_W'(page) * ADDR_W'(SCREEN_WIDTH);

	assign last_px = (cur_x_q == xh_q) && (cur_y_q == yh_q);

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				xa_q  <= x_a;
				ya_q  <= y_a;
				xb_q  <= x_b;
				yb_q  <= y_b;
				w_q   <= rect_width;
				h_q   <= rect_height;
				r_q   <= circle_radius;
				ink_q <= ink;
				bi_q  <= byte_index;
				case (req_type)
					REQ_PIXEL:   kind_q <= K_PIXEL;
					REQ_OUTLINE: kind_q <= K_OUTLINE;
					REQ_FILL:    kind_q <= K_FILL;
					REQ_LINE:    kind_q <= K_LINE;
					REQ_DISC:    kind_q <= K_DISC;
					REQ_READ:    kind_q <= K_READ;
					default:     kind_q <= K_NONE;
				endcase
			end
			OP_BOX: begin
				xl_q    <= clip_lo(bx_lo);
				xh_q    <= clip_hi(bx_hi, XMAX);
				yl_q    <= clip_lo(by_lo);
				yh_q    <= clip_hi(by_hi, YMAX);
				cur_x_q <= clip_lo(bx_lo);
				cur_y_q <= clip_lo(by_lo);
				r2_q    <= (2*CW)'(r_q) * (2*CW)'(r_q);
			end
			OP_LINE_A: begin
				sqx_q <= unsigned'((2*CW)'(dx_c * dx_c));
				sqy_q <= unsigned'((2*CW)'(dy_c * dy_c));
			end
			OP_LINE_B: begin
				xmaj_q <= sqx_q > sqy_q;
			end
			OP_LINE_C: begin
				ms_q <= m_s;
				me_q <= m_e;
				ns_q <= n_s;
				ne_q <= n_e;
			end
			OP_LINE_D: begin
				d_q  <= d_c;
				dn_q <= dn_c;
				if (d_c == 0) begin
					// both ends coincide: a single pixel at the start
					kind_q  <= K_PIXEL;
					xl_q    <= clip_lo(xa_e);
					xh_q    <= clip_hi(xa_e, XMAX);
					yl_q    <= clip_lo(ya_e);
					yh_q    <= clip_hi(ya_e, YMAX);
					cur_x_q <= xa_e;
					cur_y_q <= ya_e;
				end else begin
					xl_q    <= t_lo;
					xh_q    <= t_hi;
					yl_q    <= '0;
					yh_q    <= '0;
					cur_x_q <= t_lo;
					cur_y_q <= '0;
				end
				p1_q <= ne_q * d_c;
				p2_q <= dn_c * (t_lo - me_q);
			end
			OP_CALC: begin
				sqdx_q <= unsigned'((2*CW)'(ddx * ddx));
				sqdy_q <= unsigned'((2*CW)'(ddy * ddy));
				num_q  <= num_cur;
			end
			OP_READ: begin
				addr_q <= addr_c;
				mask_q <= 8'b1 << px_y[2:0];
				hit_q  <= shape_hit && on_screen;
			end
			OP_WRITE: begin
				num_q <= num_q + NUM_W'(dn_q);
				if (cur_x_q == xh_q) begin
					cur_x_q <= xl_q;
					cur_y_q <= cur_y_q + crd_t'(1);
				end else begin
					cur_x_q <= cur_x_q + crd_t'(1);
				end
			end
			OP_RDBYTE: begin
				rd_ok_q <= 32'(bi_q) < 32'(STORE_BYTES);
			end
			default: begin
			end
		endcase
	end

	// single write port, single registered read port
	assign mem_we = (cmd.op == OP_CLEAR) || (cmd.op == OP_WRITE && hit_q);
	assign waddr  = (cmd.op == OP_CLEAR) ? clr_q : addr_q;
	assign wdata  = (cmd.op == OP_CLEAR) ? 8'h00 :
		(ink_q ? (rd_q | mask_q) : (rd_q & ~mask_q));
	assign mem_re = (cmd.op == OP_READ) || (cmd.op == OP_RDBYTE);
	assign raddr  = (cmd.op == OP_RDBYTE) ? ADDR_W'(bi_q) : addr_c;

	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= wdata;
		if (mem_re) rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.op == OP_CLEAR) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_RESULT) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_RESULT) begin
			is_read_q   <= (kind_q == K_READ);
			read_data_q <= (kind_q == K_READ && rd_ok_q) ? rd_q : 8'h00;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign is_read   = is_read_q;

	assign stat.clr_last  = (clr_q == ADDR_W'(STORE_BYTES - 1));
	assign stat.box_empty = (xl_q > xh_q) || (yl_q > yh_q);
	assign stat.last_px   = last_px;
	assign stat.is_line   = (kind_q == K_LINE);
	assign stat.div_done  = div_done;
	assign stat.out_free  = !out_valid_q || !out_stall;

endmodule

FILE: rtl/page_framebuffer_draw_engine.sv
`timescale 1ns / 1ps
// Page-organised monochrome frame store with a drawing engine. Pixel (x,y)
// sits in byte x + (y/8)*SCREEN_WIDTH at bit y%8. One command word is taken
// at a time and answered with exactly one result word: set/clear a pixel,
// rectangle outline, filled rectangle, line, filled circle (dx^2+dy^2 < r^2),
// or read back one store byte. All drawing is clipped to the screen. After
// reset the store is swept to zero, one byte a clock, while in_stall is
// held high. Each drawn pixel is a read-modify-write of its byte through the
// single store port; boxes and circles visit every pixel of the clipped
// window, while a line takes one step per major coordinate, whose minor
// coordinate comes from a one-bit-per-clock divider. Throughput thus follows
// drawn area. The next word is accepted while the previous result waits at
// the output register.
`include "page_framebuffer_draw_engine_defines.svh"
module page_framebuffer_draw_engine import pfde_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         req_type,
	input  logic signed [11:0] x_a,
	input  logic signed [11:0] y_a,
	input  logic signed [11:0] x_b,
	input  logic signed [11:0] y_b,
	input  logic [10:0]        rect_width,
	input  logic [10:0]        rect_height,
	input  logic [10:0]        circle_radius,
	input  logic               ink,
	input  logic [10:0]        byte_index,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         read_data,
	output logic               is_read
);

	// command and status between sequencer and datapath
	dp_cmd_t  cmd;
	dp_stat_t stat;

	pfde_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.req_type (req_type),
		.stat     (stat),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	pfde_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.req_type      (req_type),
		.x_a           (x_a),
		.y_a           (y_a),
		.x_b           (x_b),
		.y_b           (y_b),
		.rect_width    (rect_width),
		.rect_height   (rect_height),
		.circle_radius (circle_radius),
		.ink           (ink),
		.byte_index    (byte_index),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.read_data     (read_data),
		.is_read       (is_read)
	);

	// one word in flight: an accepted word closes the input at once
	`PFDE_ASSERT_NXT(a_one_in_flight, clk, arst_n, in_valid && !in_stall, in_stall, "second word taken while busy")
	// a result is never loaded over one that is still held
	`PFDE_ASSERT_IMP(a_no_overwrite, clk, arst_n, cmd.op == OP_RESULT, !out_valid || !out_stall, "pending result overwritten")
	// the divider only runs for lines
	`PFDE_ASSERT_IMP(a_div_line_only, clk, arst_n, cmd.div_start, stat.is_line, "divider started outside a line")
	// no word accepted during the clearing sweep
	`PFDE_ASSERT_IMP(a_clear_stalls, clk, arst_n, cmd.op == OP_CLEAR, in_stall, "input open during clearing sweep")

endmodule

FILE: tb/sv/draw_checker.sv
`timescale 1ns / 1ps
module draw_checker import pfde_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [2:0]         req_type,
	input  logic signed [11:0] x_a,
	input  logic signed [11:0] y_a,
	input  logic signed [11:0] x_b,
	input  logic signed [11:0] y_b,
	input  logic [10:0]        rect_width,
	input  logic [10:0]        rect_height,
	input  logic [10:0]        circle_radius,
	input  logic               ink,
	input  logic [10:0]        byte_index,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [7:0]         read_data,
	input  logic               is_read,
	output int                 fail_count,
	output int                 pending
);
	typedef struct packed {
		logic [7:0] data;
		logic       rd;
	} answer_t;

	logic [7:0] shadow [STORE_BYTES];
	answer_t    answers [$];

	assign pending = answers.size();

	function automatic void plot(int x, int y, logic pen);
		int idx;
		if (x < 0 || x >= SCREEN_WIDTH || y < 0 || y >= SCREEN_HEIGHT)
			return;
		idx = x + (y / PAGE_ROWS) * SCREEN_WIDTH;
		shadow[idx][y % PAGE_ROWS] = pen;
	endfunction

	function automatic void box(int x0, int y0, int x1, int y1, logic pen);
		int xl, xh, yl, yh;
		xl = x0 < 0 ? 0 : x0;
		xh = x1 > SCREEN_WIDTH - 1 ? SCREEN_WIDTH - 1 : x1;
		yl = y0 < 0 ? 0 : y0;
		yh = y1 > SCREEN_HEIGHT - 1 ? SCREEN_HEIGHT - 1 : y1;
		for (int y = yl; y <= yh; y++)
			for (int x = xl; x <= xh; x++)
				plot(x, y, pen);
	endfunction

	function automatic void line(int xs, int ys, int xe, int ye, logic pen);
		longint dx, dy, d, dn, num;
		bit     xmaj;
		int     ms, me, ns, ne, lim, s, n, lo, hi;
		dx = longint'(xe) - longint'(xs);
		dy = longint'(ye) - longint'(ys);
		xmaj = dx * dx > dy * dy;
		if (xmaj) begin
			ms = xs; me = xe; ns = ys; ne = ye; lim = SCREEN_WIDTH;
		end else begin
			ms = ys; me = ye; ns = xs; ne = xe; lim = SCREEN_HEIGHT;
		end
		if (ms > me) begin
			s = ms; ms = me; me = s;
			s = ns; ns = ne; ne = s;
		end
		d = longint'(me) - longint'(ms);
		dn = longint'(ne) - longint'(ns);
		if (d == 0) begin
			plot(xs, ys, pen);
			return;
		end
		lo = ms < 0 ? 0 : ms;
		hi = me > lim - 1 ? lim - 1 : me;
		for (int t = lo; t <= hi; t++) begin
			// SV division truncates toward zero, as wanted
			num = longint'(ne) * d + dn * (longint'(t) - me);
			n = int'(num / d);
			if (xmaj)
				plot(t, n, pen);
			else
				plot(n, t, pen);
		end
	endfunction

	function automatic void disc(int cx, int cy, int r, logic pen);
		longint r2, ddx, ddy;
		int xl, xh, yl, yh;
		r2 = longint'(r) * r;
		xl = cx - r < 0 ? 0 : cx - r;
		xh = cx + r > SCREEN_WIDTH - 1 ? SCREEN_WIDTH - 1 : cx + r;
		yl = cy - r < 0 ? 0 : cy - r;
		yh = cy + r > SCREEN_HEIGHT - 1 ? SCREEN_HEIGHT - 1 : cy + r;
		for (int x = xl; x <= xh; x++)
			for (int y = yl; y <= yh; y++) begin
				ddx = longint'(x - cx);
				ddy = longint'(y - cy);
				if (ddx * ddx + ddy * ddy < r2)
					plot(x, y, pen);
			end
	endfunction

	function automatic answer_t draw(logic [2:0] code, int xa, int ya, int xb, int yb,
			int w, int h, int r, logic pen, int bi);
		answer_t a;
		a = '0;
		case (code)
			REQ_PIXEL: plot(xa, ya, pen);
			REQ_OUTLINE: begin
				box(xa, ya, xa + w, ya, pen);
				box(xa, ya + h, xa + w, ya + h, pen);
				box(xa, ya, xa, ya + h, pen);
				box(xa + w, ya, xa + w, ya + h, pen);
			end
			REQ_FILL: box(xa, ya, xa + w, ya + h, pen);
			REQ_LINE: line(xa, ya, xb, yb, pen);
			REQ_DISC: disc(xa, ya, r, pen);
			REQ_READ: begin
				a.rd = 1'b1;
				a.data = bi < STORE_BYTES ? shadow[bi] : 8'd0;
			end
			default: ;
		endcase
		return a;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		answer_t e;
		int      errs;
		errs = 0;
		if (!arst_n) begin
			fail_count <= 0;
			answers.delete();
			foreach (shadow[i])
				shadow[i] = 8'd0;
		end else begin
			if (in_valid && !in_stall)
				answers.push_back(draw(req_type, int'(x_a), int'(y_a), int'(x_b),
					int'(y_b), int'(rect_width), int'(rect_height),
					int'(circle_radius), ink, int'(byte_index)));
			if (out_valid && !out_stall) begin
				if (answers.size() == 0) begin
					$error("unexpected result word");
					errs++;
				end else begin
					e = answers.pop_front();
					if (read_data !== e.data) begin
						$error("read_data exp %0h got %0h", e.data, read_data);
						errs++;
					end
					if (is_read !== e.rd) begin
						$error("is_read exp %0b got %0b", e.rd, is_read);
						errs++;
					end
				end
			end
			if (errs != 0)
				fail_count <= fail_count + errs;
		end
	end
endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
	import pfde_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [2:0]         req_type = '0;
	logic signed [11:0] x_a = '0, y_a = '0, x_b = '0, y_b = '0;
	logic [10:0]        rect_width = '0, rect_height = '0, circle_radius = '0;
	logic               ink = 1'b0;
	logic [10:0]        byte_index = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [7:0]         read_data;
	logic               is_read;
	int                 fail_count, pending;
	int                 cycles = 0;
	bit                 stim_done = 1'b0;
	bit                 hold_off = 1'b0;

	always #5 clk = ~clk;

	page_framebuffer_draw_engine dut (.*);

	draw_checker chk (.*);

	// generous watchdog, since large fills, circles and lines take long to draw
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver: own stall pattern, quiet stretches, and one long hold-off
	initial begin
		int mode;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(5, 60)) begin
				@(negedge clk);
				if (hold_off)
					out_stall <= 1'b1;
				else if (mode == 0)
					out_stall <= 1'b0;
				else
					out_stall <= ($urandom_range(0, 3) < mode);
			end
		end
	end

	initial begin
		@(posedge arst_n);
		repeat (2000) @(posedge clk);
		hold_off = 1'b1;
		repeat (3000) @(posedge clk);
		hold_off = 1'b0;
	end

	// one word; waits for acceptance, keeping valid high within a burst
	task automatic send(logic [2:0] c, int xa, int ya, int xb, int yb,
			int w, int h, int r, logic pen, int bi);
		req_type <= c;
		x_a <= 12'(xa); y_a <= 12'(ya); x_b <= 12'(xb); y_b <= 12'(yb);
		rect_width <= 11'(w); rect_height <= 11'(h); circle_radius <= 11'(r);
		ink <= pen; byte_index <= 11'(bi);
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic gap();
		in_valid <= 1'b0;
		repeat ($urandom_range(1, 6)) @(negedge clk);
	endtask

	function automatic int onscreen_x();
		return $urandom_range(0, 15) == 0 ? $urandom_range(0, 4095) - 2048
			: $urandom_range(0, SCREEN_WIDTH + 9) - 5;
	endfunction

	function automatic int onscreen_y();
		return $urandom_range(0, 15) == 0 ? $urandom_range(0, 4095) - 2048
			: $urandom_range(0, SCREEN_HEIGHT + 9) - 5;
	endfunction

	function automatic int span();
		// mostly small sizes, now and then anything up to full range
		return $urandom_range(0, 31) == 0 ? $urandom_range(0, 2047)
			: $urandom_range(0, 20);
	endfunction

	initial begin
		int burst;
		logic [2:0] c;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: field extremes, each command, special cases
		send(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		send(REQ_PIXEL, 0, 0, 0, 0, 0, 0, 0, 1, 0);
		send(REQ_PIXEL, SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1, 0, 0, 0, 0, 0, 1, 0);
		send(REQ_PIXEL, -2048, 2047, -1, -1, 2047, 2047, 2047, 1, 2047);
		send(REQ_PIXEL, 2047, -2048, 2047, -2048, 0, 0, 0, 1, 0);
		send(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		send(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, STORE_BYTES - 1);
		send(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, STORE_BYTES);
		send(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 2047);
		send(REQ_OUTLINE, 3, 2, 0, 0, 20, 10, 0, 1, 0);
		send(REQ_OUTLINE, -2048, -2048, 0, 0, 2047, 2047, 0, 1, 0);
		send(REQ_FILL, 10, 10, 0, 0, 5, 30, 0, 1, 0);
		send(REQ_FILL, 12, 12, 0, 0, 0, 0, 0, 0, 0);
		send(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 12 + SCREEN_WIDTH);
		send(REQ_LINE, 0, 0, 40, 20, 0, 0, 0, 1, 0);
		send(REQ_LINE, 30, 60, 10, 0, 0, 0, 0, 1, 0);
		send(REQ_LINE, 5, 5, 25, 25, 0, 0, 0, 1, 0);   // tie goes to y
		send(REQ_LINE, 50, 20, 50, 20, 0, 0, 0, 1, 0); // zero length
		send(REQ_LINE, -2048, 2047, 2047, -2048, 0, 0, 0, 0, 0);
		send(REQ_DISC, 60, 30, 0, 0, 0, 0, 0, 1, 0);   // zero radius
		send(REQ_DISC, 60, 30, 0, 0, 0, 0, 12, 1, 0);
		send(REQ_DISC, 60, 30, 0, 0, 0, 0, 5, 0, 0);
		send(3'd6, 1, 1, 0, 0, 0, 0, 0, 1, 3);
		send(3'd7, 1, 1, 0, 0, 0, 0, 0, 1, 3);
		send(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 60 + 3 * SCREEN_WIDTH);
		gap();

		// random bursts; reads interleaved to expose store contents
		for (int n = 0; n < 900; n += burst) begin
			burst = $urandom_range(1, 12);
			for (int k = 0; k < burst; k++) begin
				c = $urandom_range(0, 15) == 0 ? 3'($urandom_range(6, 7))
					: $urandom_range(0, 9) >= 6 ? REQ_READ : 3'($urandom_range(0, 4));
				send(c, onscreen_x(), onscreen_y(), onscreen_x(), onscreen_y(),
					span(), span(), c == REQ_DISC ? span() : $urandom_range(0, 2047),
					1'($urandom_range(0, 1)),
					$urandom_range(0, 7) == 0 ? $urandom_range(0, 2047)
						: $urandom_range(0, STORE_BYTES - 1));
			end
			if ($urandom_range(0, 2) != 0)
				gap();
		end
		in_valid <= 1'b0;
		stim_done = 1'b1;
	end

	initial begin
		wait (stim_done);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
